FILE: rtl/bb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_pkg
// Shared types, constants and arithmetic helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb_pkg;

    localparam int DEF_MAX_WIDTH = 2048;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int CSUM_W     = 10;   // three 8-bit samples
    localparam int WSUM_W     = 12;   // nine 8-bit samples plus rounding bias
    localparam int NUM_CELLS  = 3;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = WSUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 16;

    // floor(x / 9) == (x * 7282) >> 16 for every x below 2300
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam logic [WSUM_W-1:0]  ROUND_BIAS = 12'd4;

    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [FW_W-1:0] DEF_FRAME_WIDTH  = 12'd640;
    localparam logic [FH_W-1:0] DEF_FRAME_HEIGHT = 16'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // where a result pixel comes from
    typedef enum logic [1:0] {
        SRC_CORNER,
        SRC_ABOVE,
        SRC_CENTER,
        SRC_MEAN
    } src_t;

    // channel 0 is red in the low byte
    typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
    typedef logic [NUM_CH-1:0][CSUM_W-1:0] col_sum_t;
    typedef logic [NUM_CH-1:0][WSUM_W-1:0] win_sum_t;

    // one window column: its middle pixel and its per-channel sum
    typedef struct packed {
        pixel_t   center;
        col_sum_t sum;
    } col_t;

    // one line buffer entry: pixel two rows back and one row back
    typedef struct packed {
        pixel_t top;
        pixel_t above;
    } line_pair_t;

    function automatic col_t col_of(input pixel_t top, input pixel_t above,
                                    input pixel_t cur);
        col_t res;
        res.center = above;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            res.sum[ch] = CSUM_W'(top[ch]) + CSUM_W'(above[ch]) + CSUM_W'(cur[ch]);
        end
        return res;
    endfunction

    // biased window sum divided by nine
    function automatic pixel_t window_mean(input win_sum_t total);
        pixel_t             res;
        logic [PROD_W-1:0]  prod;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod    = PROD_W'(total[ch]) * PROD_W'(RECIP_NINE);
            res[ch] = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        end
        return res;
    endfunction

endpackage

FILE: rtl/box_blur_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3
// 3x3 box blur over an RGB raster stream with a two-line buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser = 0 brings a pixel, s_tuser = 1 is a drain
//   tick. Interior pixels leave as the rounded 3x3 mean, border pixels leave
//   unchanged, one row plus one pixel behind the input. After the frame's
//   last pixel each drain tick releases one pending pixel; the frame's final
//   pixel leaves with m_tlast high. A drain tick with nothing pending is
//   taken and produces nothing.
//   cfg_we/cfg_addr/cfg_wdata write frame_width (0) and frame_height (1);
//   a write restarts the frame position and drops pending pixels.
// Timing:
//   one request per clock while s_tready is high; a result passes stage 1, stage 2
//   and the output register. The line buffer is one read-plus-write memory port
//   pair touched once per request, and the window is a chain of three column cells.
// Reset:
//   clears position, pending count and all valid flags, loads 640 x 480.
// Stall:
//   the output register holds its pixel while m_tready is low; s_tready stays
//   high until both pipeline stages and the output register are full and m_tready is low.
// ----------------------------------------------------------------------------
module box_blur_3x3
    import bb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH + 2);

    // configuration and frame position
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [FH_W-1:0]  row_reg, row_next;
    logic [PW-1:0]    pending_reg, pending_next;

    logic [WW-1:0]    w_eff;
    logic [COL_W-1:0] wm1;
    logic [FH_W-1:0]  hm1;
    logic [PW-1:0]    pend_full;

    // request decode
    logic             accept;
    logic             ld_valid, ld_pixel, ld_emit, ld_cap, ld_last;
    logic [COL_W-1:0] ld_addr;
    src_t             ld_src;

    // stage 1: line buffer data returns
    logic             s1_valid_reg, s1_pixel_reg, s1_emit_reg, s1_cap_reg, s1_last_reg;
    logic [COL_W-1:0] s1_addr_reg;
    pixel_t           s1_pix_reg;
    src_t             s1_src_reg;
    logic             s1_go, s1_free;

    line_pair_t       mem_rd, rd_col, wr_data;
    logic             wr_en, byp_hit;
    logic             byp_hit_reg;
    line_pair_t       byp_data_reg;
    pixel_t           corner_reg;

    // stage 2: window ready
    logic             s2_valid_reg, s2_last_reg;
    src_t             s2_src_reg;
    pixel_t           s2_val_reg;
    pixel_t           s2_result;
    logic             s2_go, s2_free;

    // output register
    logic             out_valid_reg, out_last_reg;
    pixel_t           out_pix_reg;
    logic             out_free;

    // window cells
    col_t             new_col;
    col_t             col_chain  [NUM_CELLS+1];
    win_sum_t         part_chain [NUM_CELLS+1];

    // ------------------------------------------------------------------
    // effective frame size
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end
        wm1       = COL_W'(w_eff - WW'(1));
        hm1       = (frame_height_reg == '0) ? '0 : frame_height_reg - FH_W'(1);
        // a one-row frame has no extra corner pixel to drain
        pend_full = PW'(w_eff) + ((hm1 == '0) ? PW'(0) : PW'(1));
    end

    // ------------------------------------------------------------------
    // handshake chain
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;
    assign s2_go    = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // request decode and position counters
    // ------------------------------------------------------------------
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        ld_valid     = 1'b0;
        ld_pixel     = 1'b0;
        ld_emit      = 1'b0;
        ld_cap       = 1'b0;
        ld_last      = 1'b0;
        ld_src       = SRC_CORNER;
        ld_addr      = col_reg;
        if (cfg_we)
        begin
            col_next     = '0;
            row_next     = '0;
            pending_next = '0;
        end
        else if (accept)
        begin
            if (!s_tuser)
            begin
                pending_next = '0;
                ld_valid     = 1'b1;
                ld_pixel     = 1'b1;
                ld_cap       = (col_reg == wm1);
                if (col_reg == '0 && row_reg >= FH_W'(2))
                begin
                    // right border pixel of the row two back
                    ld_emit = 1'b1;
                    ld_src  = SRC_CORNER;
                end
                else if (col_reg != '0 && row_reg != '0)
                begin
                    ld_emit = 1'b1;
                    ld_src  = (col_reg >= COL_W'(2) && row_reg >= FH_W'(2)) ?
                              SRC_MEAN : SRC_CENTER;
                end
                if (col_reg == wm1)
                begin
                    col_next = '0;
                    if (row_reg == hm1)
                    begin
                        row_next     = '0;
                        pending_next = pend_full;
                    end
                    else
                    begin
                        row_next = row_reg + FH_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            else if (pending_reg != '0)
            begin
                ld_valid     = 1'b1;
                ld_emit      = 1'b1;
                ld_last      = (pending_reg == PW'(1));
                pending_next = pending_reg - PW'(1);
                ld_addr      = COL_W'(PW'(w_eff) - pending_reg);
                ld_src       = (pending_reg <= PW'(w_eff)) ? SRC_ABOVE : SRC_CORNER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DEF_FRAME_WIDTH;
            frame_height_reg <= DEF_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            pending_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                endcase
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffer
    // ------------------------------------------------------------------
    assign wr_en         = s1_go && s1_pixel_reg;
    assign wr_data.top   = rd_col.above;
    assign wr_data.above = s1_pix_reg;
    // a read issued while the same column is written returns stale data
    assign byp_hit       = wr_en && (s1_addr_reg == ld_addr);
    assign rd_col        = byp_hit_reg ? byp_data_reg : mem_rd;

    bb_line_mem #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (ld_addr),
        .rd_data (mem_rd)
    );

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= ld_valid;
                byp_hit_reg  <= byp_hit;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= ld_pixel;
            s1_emit_reg  <= ld_emit;
            s1_cap_reg   <= ld_cap;
            s1_last_reg  <= ld_last;
            s1_src_reg   <= ld_src;
            s1_addr_reg  <= ld_addr;
            s1_pix_reg   <= pixel_t'(s_tdata);
            byp_data_reg <= wr_data;
        end
        if (wr_en && s1_cap_reg)
        begin
            corner_reg <= rd_col.above;
        end
    end

    // ------------------------------------------------------------------
    // window: column cells, newest on the right
    // ------------------------------------------------------------------
    assign new_col                = col_of(rd_col.top, rd_col.above, s1_pix_reg);
    assign col_chain[NUM_CELLS]   = new_col;
    assign part_chain[0]          = {NUM_CH{ROUND_BIAS}};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bb_cell u_cell (
            .clk      (clk),
            .shift    (wr_en),
            .col_in   (col_chain[i+1]),
            .part_in  (part_chain[i]),
            .col_q    (col_chain[i]),
            .part_out (part_chain[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s2_valid_reg <= s1_emit_reg;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_src_reg  <= s1_src_reg;
            s2_last_reg <= s1_last_reg;
            s2_val_reg  <= (s1_src_reg == SRC_ABOVE) ? rd_col.above : corner_reg;
        end
    end

    always_comb
    begin
        unique case (s2_src_reg)
            SRC_CORNER: s2_result = s2_val_reg;
            SRC_ABOVE:  s2_result = s2_val_reg;
            SRC_CENTER: s2_result = col_chain[1].center;
            SRC_MEAN:   s2_result = window_mean(part_chain[NUM_CELLS]);
            default:    s2_result = s2_val_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            out_pix_reg  <= s2_result;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PW'(w_eff) + PW'(1))
        else $error("drain count above width plus one");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wm1)
        else $error("column position beyond frame width");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with a free pipeline slot");

endmodule

FILE: rtl/bb_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_line_mem
// Two-line pixel buffer, one entry per column, one write and one read port.
// ----------------------------------------------------------------------------
module bb_line_mem
    import bb_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  line_pair_t               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output line_pair_t               rd_data
);

    line_pair_t mem_array [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_cell
// One column of the 3x3 window; shifts to its left neighbor and adds its
// column sum onto the running window sum.
// ----------------------------------------------------------------------------
module bb_cell
    import bb_pkg::*;
(
    input  logic     clk,
    input  logic     shift,
    input  col_t     col_in,
    input  win_sum_t part_in,
    output col_t     col_q,
    output win_sum_t part_out
);

    col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            part_out[ch] = part_in[ch] + WSUM_W'(col_reg.sum[ch]);
        end
    end

    assign col_q = col_reg;

endmodule
